// ===== hdl/tst_pkg.sv =====
// Shared definitions for the timer slot table: sizes, op and result codes,
// result record and controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tst_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam int OP_W      = 2;
   localparam int ID_W      = 16;
   localparam int DELAY_W   = 31;
   localparam int SPAN_W    = 25;
   localparam int TICK_W    = 32;
   localparam int RES_W     = 2;
   localparam int IDX_OUT_W = 4;

   // Division by 100 as a multiply by ceil(2^37 / 100) and a shift by 37.
   localparam int                PROD_W    = 64;
   localparam int                DIV_SHIFT = 37;
   localparam logic [TICK_W-1:0] DIV_MAGIC = 32'h51EB851F;

   typedef enum logic [OP_W-1:0] {
      OP_SET    = 2'd0,
      OP_REBASE = 2'd1,
      OP_KILL   = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [RES_W-1:0] {
      RES_EXPIRED   = 2'd0,
      RES_DONE      = 2'd1,
      RES_FULL      = 2'd2,
      RES_NOT_FOUND = 2'd3
   } res_type;

   typedef struct packed {
      res_type               res;
      logic [ID_W-1:0]       id;
      logic [IDX_OUT_W-1:0]  slot;
      logic                  last;
   } rsp_item_type;

   typedef struct packed {
      logic start;   // capture the accepted item and restart the scan
      logic scan;    // advance the slot scan
      logic finish;  // commit the table update and deliver the closing result
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } ctl_sts_type;

endpackage

`default_nettype wire

// ===== hdl/tst_if.sv =====
// Valid/ready channel interfaces for the timer slot table's command and result streams.
// Depends on tst_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tst_req_if;
   logic                         valid;
   logic                         ready;
   logic [tst_pkg::OP_W-1:0]     op;
   logic [tst_pkg::ID_W-1:0]     timer_id;
   logic [tst_pkg::DELAY_W-1:0]  delay_ms;

   modport source (output valid, op, timer_id, delay_ms, input ready);
   modport sink   (input valid, op, timer_id, delay_ms, output ready);
endinterface

interface tst_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tst_pkg::RES_W-1:0]      event_res;
   logic [tst_pkg::ID_W-1:0]       event_id;
   logic [tst_pkg::IDX_OUT_W-1:0]  slot_index;
   logic                           last;

   modport source (output valid, event_res, event_id, slot_index, last, input ready);
   modport sink   (input valid, event_res, event_id, slot_index, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/tst_ctrl.sv =====
// Sequencing state machine of the timer slot table: idle, slot scan, commit.
// Depends on tst_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tst_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire tst_pkg::ctl_sts_type sts,
   output tst_pkg::ctl_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The closing result needs the output register to be free.
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tst_datapath.sv =====
// Datapath of the timer slot table: slot memories, valid bits, tick counter, scan
// pipeline, span divider and output register. Depends on tst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tst_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tst_pkg::ctl_cmd_type           cmd,
   output tst_pkg::ctl_sts_type                sts,
   input  wire logic [tst_pkg::OP_W-1:0]       req_op,
   input  wire logic [tst_pkg::ID_W-1:0]       req_timer_id,
   input  wire logic [tst_pkg::DELAY_W-1:0]    req_delay_ms,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [tst_pkg::RES_W-1:0]           rsp_event_res,
   output logic [tst_pkg::ID_W-1:0]            rsp_event_id,
   output logic [tst_pkg::IDX_OUT_W-1:0]       rsp_slot_index,
   output logic                                rsp_last
);

   // Slot storage, one read port feeding the scan.
   logic [tst_pkg::ID_W-1:0]    id_mem   [tst_pkg::SLOTS];
   logic [tst_pkg::TICK_W-1:0]  base_mem [tst_pkg::SLOTS];
   logic [tst_pkg::SPAN_W-1:0]  span_mem [tst_pkg::SLOTS];

   logic [tst_pkg::SLOTS-1:0]   valid_ff, valid_in;
   logic [tst_pkg::TICK_W-1:0]  tick_ff, tick_in;

   tst_pkg::op_type             op_ff;
   logic [tst_pkg::ID_W-1:0]    id_ff;
   logic [tst_pkg::SPAN_W-1:0]  span_ff, span_in;
   logic [tst_pkg::PROD_W-1:0]  prod;

   logic [tst_pkg::CNT_W-1:0]   addr_ff;
   logic                        chk_vld_ff;
   logic [tst_pkg::SLOT_W-1:0]  chk_idx_ff;
   logic [tst_pkg::ID_W-1:0]    rd_id_ff;
   logic [tst_pkg::TICK_W-1:0]  rd_base_ff;
   logic [tst_pkg::SPAN_W-1:0]  rd_span_ff;

   logic                        match_fnd_ff, free_fnd_ff;
   logic [tst_pkg::SLOT_W-1:0]  match_idx_ff, free_idx_ff;
   logic [tst_pkg::RES_CNT_W-1:0] cnt_ff;

   logic                        pend_vld_ff;
   tst_pkg::rsp_item_type       pend_ff;
   logic                        out_vld_ff;
   tst_pkg::rsp_item_type       out_ff;

   logic                        out_free, chk_valid, expire, stall, adv, chk_eval;
   logic                        id_hit, addr_end, is_tick, scan_push, fin_push;
   logic [tst_pkg::TICK_W-1:0]  age;
   tst_pkg::rsp_item_type       fin_item;

   assign prod    = tst_pkg::PROD_W'(req_delay_ms) * tst_pkg::PROD_W'(tst_pkg::DIV_MAGIC);
   assign span_in = prod[tst_pkg::DIV_SHIFT +: tst_pkg::SPAN_W];
   assign tick_in = tick_ff + 1'b1;

   assign is_tick   = (op_ff == tst_pkg::OP_TICK);
   assign out_free  = !out_vld_ff || rsp_ready;
   assign chk_valid = valid_ff[chk_idx_ff];
   assign age       = tick_ff - rd_base_ff;
   assign expire    = is_tick && chk_vld_ff && chk_valid
                      && (age >= tst_pkg::TICK_W'(rd_span_ff))
                      && (cnt_ff < tst_pkg::RES_CNT_W'(tst_pkg::MAX_RESULTS));
   // An expiry can only be taken when the held report has somewhere to go.
   assign stall     = expire && pend_vld_ff && !out_free;
   assign adv       = cmd.scan && !stall;
   assign chk_eval  = adv && chk_vld_ff;
   assign id_hit    = chk_valid && (rd_id_ff == id_ff);
   assign addr_end  = (addr_ff == tst_pkg::CNT_W'(tst_pkg::SLOTS));
   assign scan_push = chk_eval && expire && pend_vld_ff;

   assign sts.scan_done = addr_end && !chk_vld_ff;
   assign sts.out_free  = out_free;

   always_comb begin
      fin_push      = 1'b1;
      fin_item.res  = tst_pkg::RES_DONE;
      fin_item.id   = id_ff;
      fin_item.slot = '0;
      fin_item.last = 1'b1;
      case (op_ff)
         tst_pkg::OP_SET: begin
            if (free_fnd_ff) begin
               fin_item.slot = tst_pkg::IDX_OUT_W'(free_idx_ff);
            end else begin
               fin_item.res = tst_pkg::RES_FULL;
            end
         end
         tst_pkg::OP_REBASE, tst_pkg::OP_KILL: begin
            if (match_fnd_ff) begin
               fin_item.slot = tst_pkg::IDX_OUT_W'(match_idx_ff);
            end else begin
               fin_item.res = tst_pkg::RES_NOT_FOUND;
            end
         end
         tst_pkg::OP_TICK: begin
            fin_push      = pend_vld_ff;
            fin_item      = pend_ff;
            fin_item.last = 1'b1;
         end
         default: begin
            fin_push = 1'b0;
         end
      endcase
   end

   // Next value of the valid bits.
   always_comb begin
      valid_in = valid_ff;
      if (chk_eval && expire) begin
         valid_in[chk_idx_ff] = 1'b0;
      end
      if (cmd.finish) begin
         // The freed duplicate is cleared first so that reuse of its slot wins.
         if (((op_ff == tst_pkg::OP_SET) || (op_ff == tst_pkg::OP_KILL))
             && match_fnd_ff) begin
            valid_in[match_idx_ff] = 1'b0;
         end
         if ((op_ff == tst_pkg::OP_SET) && free_fnd_ff) begin
            valid_in[free_idx_ff] = 1'b1;
         end
      end
   end

   // Memory read and write ports.
   always_ff @(posedge clock) begin
      if (adv && !addr_end) begin
         rd_id_ff   <= id_mem[addr_ff[tst_pkg::SLOT_W-1:0]];
         rd_base_ff <= base_mem[addr_ff[tst_pkg::SLOT_W-1:0]];
         rd_span_ff <= span_mem[addr_ff[tst_pkg::SLOT_W-1:0]];
         chk_idx_ff <= addr_ff[tst_pkg::SLOT_W-1:0];
      end
      if (cmd.finish && (op_ff == tst_pkg::OP_SET) && free_fnd_ff) begin
         id_mem[free_idx_ff]   <= id_ff;
         base_mem[free_idx_ff] <= tick_ff;
         span_mem[free_idx_ff] <= span_ff;
      end
      if (cmd.finish && (op_ff == tst_pkg::OP_REBASE) && match_fnd_ff) begin
         base_mem[match_idx_ff] <= tick_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff   <= tst_pkg::op_type'(req_op);
         id_ff   <= req_timer_id;
         span_ff <= span_in;
      end
      if (chk_eval && !is_tick) begin
         if (id_hit && !match_fnd_ff) begin
            match_idx_ff <= chk_idx_ff;
         end
         if ((!chk_valid || id_hit) && !free_fnd_ff) begin
            free_idx_ff <= chk_idx_ff;
         end
      end
      if (chk_eval && expire) begin
         pend_ff.res  <= tst_pkg::RES_EXPIRED;
         pend_ff.id   <= rd_id_ff;
         pend_ff.slot <= tst_pkg::IDX_OUT_W'(chk_idx_ff);
         pend_ff.last <= 1'b0;
      end
      if (scan_push) begin
         out_ff <= pend_ff;
      end else if (cmd.finish && fin_push) begin
         out_ff <= fin_item;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         tick_ff      <= '0;
         addr_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         match_fnd_ff <= 1'b0;
         free_fnd_ff  <= 1'b0;
         cnt_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.start) begin
            if (tst_pkg::op_type'(req_op) == tst_pkg::OP_TICK) begin
               tick_ff <= tick_in;
            end
            addr_ff      <= '0;
            chk_vld_ff   <= 1'b0;
            match_fnd_ff <= 1'b0;
            free_fnd_ff  <= 1'b0;
            cnt_ff       <= '0;
            pend_vld_ff  <= 1'b0;
         end
         if (adv) begin
            chk_vld_ff <= !addr_end;
            if (!addr_end) begin
               addr_ff <= addr_ff + 1'b1;
            end
         end
         if (chk_eval && !is_tick) begin
            if (id_hit) begin
               match_fnd_ff <= 1'b1;
            end
            if (!chk_valid || id_hit) begin
               free_fnd_ff <= 1'b1;
            end
         end
         if (chk_eval && expire) begin
            cnt_ff      <= cnt_ff + 1'b1;
            pend_vld_ff <= 1'b1;
         end
         if (cmd.finish) begin
            pend_vld_ff <= 1'b0;
         end
         if (scan_push || (cmd.finish && fin_push)) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_event_res  = out_ff.res;
   assign rsp_event_id   = out_ff.id;
   assign rsp_slot_index = out_ff.slot;
   assign rsp_last       = out_ff.last;

endmodule

`default_nettype wire

// ===== hdl/timer_slot_table.sv =====
// Top level of the timer slot table: controller and datapath on two stream interfaces.
// Depends on tst_pkg, tst_if, tst_ctrl and tst_datapath.
//
//   Channel   Direction  Carries
//   req_bus   in         op, timer_id, delay_ms
//   rsp_bus   out        event_res, event_id, slot_index, last
//
// Every item scans all slots through the single read port of the slot memories,
// so no new item is taken until the scan and closing step of the last one are through.
// A tick gives up to one expiry report per slot; set, rebase and kill give one result each.
// Synchronous reset clears the tick counter, all valid bits and the output register's valid flag.
// A stalled result channel holds the scan only when a further report must go out,
// and the closing step of every item waits until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module timer_slot_table (
   input wire logic   clock,
   input wire logic   reset,
   tst_req_if.sink    req_bus,
   tst_rsp_if.source  rsp_bus
);

   tst_pkg::ctl_cmd_type cmd;
   tst_pkg::ctl_sts_type sts;

   tst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tst_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_bus.op),
      .req_timer_id   (req_bus.timer_id),
      .req_delay_ms   (req_bus.delay_ms),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_event_res  (rsp_bus.event_res),
      .rsp_event_id   (rsp_bus.event_id),
      .rsp_slot_index (rsp_bus.slot_index),
      .rsp_last       (rsp_bus.last)
   );

endmodule

`default_nettype wire

// ===== hdl/tst_checker.sv =====
// Port-level assertions for the timer slot table and the bind that attaches them.
// Depends on tst_pkg and the timer_slot_table top level.
`timescale 1ns / 1ps
`default_nettype none

module tst_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [tst_pkg::RES_W-1:0]     rsp_event_res,
   input wire logic [tst_pkg::ID_W-1:0]      rsp_event_id,
   input wire logic [tst_pkg::IDX_OUT_W-1:0] rsp_slot_index,
   input wire logic                          rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_event_res) && $stable(rsp_event_id)
                                  && $stable(rsp_slot_index) && $stable(rsp_last))
      else $error("stalled result changed");

   a_cmd_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != tst_pkg::RES_EXPIRED) |-> rsp_last)
      else $error("command result not marked last");

   a_noslot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_event_res == tst_pkg::RES_FULL)
                    || (rsp_event_res == tst_pkg::RES_NOT_FOUND))
      |-> (rsp_slot_index == '0))
      else $error("failed command reports a slot");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item taken while the scan runs");

endmodule

bind timer_slot_table tst_checker u_tst_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_event_res  (rsp_bus.event_res),
   .rsp_event_id   (rsp_bus.event_id),
   .rsp_slot_index (rsp_bus.slot_index),
   .rsp_last       (rsp_bus.last)
);

`default_nettype wire

// ===== bench/tb_timer_slot_table.sv =====
// Self-checking bench for timer_slot_table: a directed table followed by a random stream
// of set, rebase, kill and tick commands, checked against a behavioral copy of the table.
// Depends on tst_pkg, tst_if and the timer_slot_table RTL.
`timescale 1ns / 1ps

module tb_timer_slot_table;
   import tst_pkg::*;

   typedef struct {
      op_type              op;
      logic [ID_W-1:0]     id;
      logic [DELAY_W-1:0]  delay;
      bit                  fixed;
      rsp_item_type        want;
   } cmd_row_type;

   localparam int RANDOM_CMDS = 460;
   localparam int CALM_TAIL   = 60;

   logic clock;
   logic reset;

   tst_req_if req_bus ();
   tst_rsp_if rsp_bus ();

   timer_slot_table uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Behavioral copy of the timer table.
   logic [TICK_W-1:0]  ticks;
   bit                 live [SLOTS];
   logic [ID_W-1:0]    tag [SLOTS];
   logic [TICK_W-1:0]  base [SLOTS];
   logic [SPAN_W-1:0]  span [SLOTS];

   rsp_item_type  due_events[$];
   rsp_item_type  head;
   cmd_row_type   plan[$];
   logic [ID_W-1:0] id_pool [24];

   bit            drv_fixed;
   rsp_item_type  drv_want;
   bit            calm;
   int            err_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_diff(input string msg);
      if (err_count < 40) $display("%0t mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic int slot_of(input logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++) begin
         if (live[i] && tag[i] == id) return i;
      end
      return -1;
   endfunction

   // Applies one accepted command to the table copy and queues the results it causes.
   // Rows with a typed-in result queue that result in place of the computed one.
   task automatic table_step(input op_type op, input logic [ID_W-1:0] id,
                             input logic [DELAY_W-1:0] delay, input bit fixed,
                             input rsp_item_type want);
      int hit;
      int free;
      int n;
      logic [TICK_W-1:0] age;
      rsp_item_type r;
      rsp_item_type made[$];
      hit = slot_of(id);
      free = -1;
      n = 0;
      r = '0;
      r.id = id;
      r.last = 1'b1;
      case (op)
         OP_SET: begin
            if (hit >= 0) live[hit] = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!live[i] && free < 0) free = i;
            end
            if (free < 0) begin
               r.res = RES_FULL;
            end else begin
               live[free] = 1'b1;
               tag[free] = id;
               base[free] = ticks;
               span[free] = SPAN_W'(delay / 100);
               r.res = RES_DONE;
               r.slot = IDX_OUT_W'(free);
            end
            made.push_back(r);
         end
         OP_REBASE, OP_KILL: begin
            if (hit < 0) begin
               r.res = RES_NOT_FOUND;
            end else begin
               if (op == OP_REBASE) base[hit] = ticks;
               else live[hit] = 1'b0;
               r.res = RES_DONE;
               r.slot = IDX_OUT_W'(hit);
            end
            made.push_back(r);
         end
         default: begin
            ticks = ticks + 1;
            for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
               age = ticks - base[i];
               if (live[i] && age >= TICK_W'(span[i])) begin
                  r.res = RES_EXPIRED;
                  r.id = tag[i];
                  r.slot = IDX_OUT_W'(i);
                  r.last = 1'b0;
                  made.push_back(r);
                  live[i] = 1'b0;
                  n++;
               end
            end
            if (made.size() > 0) made[made.size() - 1].last = 1'b1;
         end
      endcase
      if (fixed) due_events.push_back(want);
      else foreach (made[k]) due_events.push_back(made[k]);
   endtask

   // Results are checked before the command of the same edge is applied, since a
   // transfer on the result side can never stem from a command accepted at that edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_events.size() == 0) begin
               flag_diff($sformatf("unexpected result res=%0d id=%h slot=%0d last=%0b",
                                   rsp_bus.event_res, rsp_bus.event_id,
                                   rsp_bus.slot_index, rsp_bus.last));
            end else begin
               head = due_events.pop_front();
               if (rsp_bus.event_res !== head.res)
                  flag_diff($sformatf("event_res %0d, want %0d", rsp_bus.event_res, head.res));
               if (rsp_bus.event_id !== head.id)
                  flag_diff($sformatf("event_id %h, want %h", rsp_bus.event_id, head.id));
               if (rsp_bus.slot_index !== head.slot)
                  flag_diff($sformatf("slot_index %0d, want %0d", rsp_bus.slot_index,
                                      head.slot));
               if (rsp_bus.last !== head.last)
                  flag_diff($sformatf("last %0b, want %0b", rsp_bus.last, head.last));
            end
         end
         if (req_bus.valid && req_bus.ready)
            table_step(op_type'(req_bus.op), req_bus.timer_id, req_bus.delay_ms,
                       drv_fixed, drv_want);
      end
   end

   // Result side back-pressure: ready runs of random length with stall bursts between.
   initial begin
      int run;
      bit level;
      rsp_bus.ready = 1'b0;
      forever begin
         if (calm || $urandom_range(0, 4) != 0) begin
            run = $urandom_range(1, 20);
            level = 1'b1;
         end else begin
            run = $urandom_range(1, 13);
            level = 1'b0;
         end
         repeat (run) begin
            @(negedge clock);
            rsp_bus.ready <= level;
         end
      end
   end

   task automatic add_row(input op_type op, input int id, input int delay, input bit fixed,
                          input res_type res, input int slot);
      cmd_row_type c;
      c.op = op;
      c.id = ID_W'(id);
      c.delay = DELAY_W'(delay);
      c.fixed = fixed;
      c.want = '0;
      c.want.res = res;
      c.want.id = ID_W'(id);
      c.want.slot = IDX_OUT_W'(slot);
      c.want.last = 1'b1;
      plan.push_back(c);
   endtask

   task automatic random_row(output cmd_row_type c);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) c.op = OP_SET;
      else if (pick < 50) c.op = OP_REBASE;
      else if (pick < 65) c.op = OP_KILL;
      else c.op = OP_TICK;
      // Ids mostly come from a small pool so that commands find their timers.
      if ($urandom_range(0, 9) == 0) c.id = ID_W'($urandom);
      else c.id = id_pool[$urandom_range(0, 23)];
      pick = $urandom_range(0, 99);
      if (pick < 60) c.delay = DELAY_W'($urandom_range(0, 1200));
      else if (pick < 85) c.delay = DELAY_W'($urandom_range(0, 99));
      else if (pick < 95) c.delay = DELAY_W'($urandom_range(0, 5000));
      else c.delay = DELAY_W'($urandom);
      c.fixed = 1'b0;
      c.want = '0;
   endtask

   task automatic push_cmd(input cmd_row_type c);
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.op       <= c.op;
      req_bus.timer_id <= c.id;
      req_bus.delay_ms <= c.delay;
      drv_fixed        <= c.fixed;
      drv_want         <= c.want;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   initial begin
      cmd_row_type c;
      req_bus.valid    = 1'b0;
      req_bus.op       = OP_SET;
      req_bus.timer_id = '0;
      req_bus.delay_ms = '0;
      drv_fixed        = 1'b0;
      drv_want         = '0;
      calm             = 1'b0;
      err_count        = 0;
      ticks            = '0;
      foreach (live[i]) begin
         live[i] = 1'b0;
         tag[i]  = '0;
         base[i] = '0;
         span[i] = '0;
      end
      foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
      id_pool[0] = '0;
      id_pool[1] = '1;

      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(OP_KILL,   16'h1234, 0,          1, RES_NOT_FOUND, 0);
      add_row(OP_TICK,   16'h0000, 'h7FFFFFFF, 0, RES_EXPIRED,   0);
      add_row(OP_SET,    16'hFFFF, 0,          1, RES_DONE,      0);
      add_row(OP_SET,    16'h5A5A, 250,        1, RES_DONE,      1);
      // Setting an id that is already present frees its slot and takes it again.
      add_row(OP_SET,    16'h5A5A, 99,         1, RES_DONE,      1);
      add_row(OP_SET,    16'h0000, 'h7FFFFFFF, 1, RES_DONE,      2);
      add_row(OP_REBASE, 16'h0000, 0,          1, RES_DONE,      2);
      add_row(OP_TICK,   16'hA5A5, 0,          0, RES_EXPIRED,   0);
      add_row(OP_REBASE, 16'hFFFF, 0,          1, RES_NOT_FOUND, 0);
      add_row(OP_KILL,   16'h0000, 0,          1, RES_DONE,      2);
      for (int k = 0; k < SLOTS; k++)
         add_row(OP_SET, 16'h8000 + 16'h0111 * k, 6 * k, 1, RES_DONE, k);
      add_row(OP_SET,    16'h7FFF, 100,        1, RES_FULL,      0);
      add_row(OP_TICK,   16'h0000, 0,          0, RES_EXPIRED,   0);

      foreach (plan[k]) begin
         if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 13));
         push_cmd(plan[k]);
      end

      for (int k = 0; k < RANDOM_CMDS; k++) begin
         if (k == RANDOM_CMDS / 2) begin
            hold_off(1);
            while (due_events.size() != 0) @(posedge clock);
         end
         if (k >= RANDOM_CMDS - CALM_TAIL) calm = 1'b1;
         if (!calm && (k / 40) % 3 != 2 && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 13));
         random_row(c);
         push_cmd(c);
      end
      hold_off(1);

      while (due_events.size() != 0) @(posedge clock);
      repeat (4 * SLOTS) @(posedge clock);
      if (due_events.size() != 0)
         flag_diff($sformatf("%0d results never arrived", due_events.size()));
      if (err_count == 0) begin
         $display("tb_timer_slot_table: clean");
      end else begin
         $display("tb_timer_slot_table: errors");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_timer_slot_table: errors");
      $finish;
   end

endmodule
